// File: rtl/weigh_frame_builder_macros.svh
// Assertion macros for the weigh frame builder.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef WEIGH_FRAME_BUILDER_MACROS_SVH
`define WEIGH_FRAME_BUILDER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication on the module clock
`define WFB_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication on the module clock
`define WFB_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define WFB_ASSERT_IMP(lbl, pre, post, msg)
`define WFB_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/wfb_pkg.sv
// Package for the weigh frame builder: frame byte codes, field widths,
// converter control type and an elaboration-time power of ten.
`timescale 1ns / 1ps
package wfb_pkg;
	localparam int BIN_W      = 17;
	localparam int DIGITS_DEF = 5;

	localparam logic [7:0] BYTE_START = 8'h0D;
	localparam logic [7:0] BYTE_SEP   = 8'h20;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] BYTE_DIG0  = 8'h30;
	localparam logic [7:0] CKS_XOR    = 8'h7F;
	localparam logic [7:0] CKS_FLOOR  = 8'h20;

	// Control of one binary-to-decimal converter
	typedef struct packed {
		logic start;
		logic shift;
	} bcd_ctrl_t;

	function automatic longint pow10(input int n);
		longint p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction
endpackage

// File: rtl/weigh_frame_builder.sv
// Channel | dir | signals                                          | item
// in      | in  | in_valid in_ready status_byte weight ident_number | one frame request
//         |     | long_frame                                       |
// out     | out | out_valid out_ready frame_byte last_byte          | one frame byte
//
// A frame is accepted, then converted in the bit-serial binary-to-BCD
// converters (one shift per input bit, then a wait to see them finish), then
// sent one byte per cycle while the output is not stalled: 5 + DIGITS bytes
// short, 6 + 2*DIGITS long.
// The output register holds each byte until taken; a stall stops the sequencer.
// in_ready rises once the last byte sits in the output register.
// Reset clears the sequencer and output valid; no clearing pass is needed.
// Depends on wfb_pkg, wfb_bcd_conv and weigh_frame_builder_macros.svh.
`timescale 1ns / 1ps
`include "weigh_frame_builder_macros.svh"
module weigh_frame_builder import wfb_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       status_byte,
	input  logic [BIN_W-1:0] weight,
	input  logic [BIN_W-1:0] ident_number,
	input  logic             long_frame,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);
	localparam longint TOP  = pow10(DIGITS);
	localparam longint MAXB = (longint'(1) << BIN_W) - 1;
	localparam logic [BIN_W-1:0] SAT_VAL = (TOP - 1 > MAXB) ? BIN_W'(MAXB) : BIN_W'(TOP - 1);
	localparam int DIG_CW = $clog2(DIGITS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CONV, S_START, S_STAT, S_WDIG, S_SEP, S_IDIG, S_ZERO, S_CKS, S_END
	} state_t;

	state_t            state_q;
	logic [7:0]        status_q;
	logic              long_q;
	logic [7:0]        sum_q;
	logic [DIG_CW-1:0] dig_q;
	logic              out_valid_q;
	logic [7:0]        frame_byte_q;
	logic              last_byte_q;

	logic              accept;
	logic              can_load;
	logic              emit;
	logic [7:0]        byte_d;
	logic [7:0]        cks_x;
	logic [7:0]        cks;
	logic [BIN_W-1:0]  weight_sat;
	logic [BIN_W-1:0]  ident_sat;
	bcd_ctrl_t         w_ctrl;
	bcd_ctrl_t         i_ctrl;
	logic              w_busy;
	logic              i_busy;
	logic [3:0]        w_digit;
	logic [3:0]        i_digit;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign can_load = !out_valid_q || out_ready;
	assign emit     = can_load && (state_q != S_IDLE) && (state_q != S_CONV);

	// Saturate values that do not fit in DIGITS digits
	assign weight_sat = (weight > SAT_VAL) ? SAT_VAL : weight;
	assign ident_sat  = (ident_number > SAT_VAL) ? SAT_VAL : ident_number;

	// Drive the converters: start on accept, shift after each digit byte
	assign w_ctrl = '{start: accept, shift: emit && (state_q == S_WDIG)};
	assign i_ctrl = '{start: accept, shift: emit && (state_q == S_IDIG)};

	wfb_bcd_conv #(.DIGITS(DIGITS)) u_wconv (
		.clk(clk), .arst_n(arst_n), .ctrl(w_ctrl), .bin_in(weight_sat),
		.busy(w_busy), .digit(w_digit)
	);

	wfb_bcd_conv #(.DIGITS(DIGITS)) u_iconv (
		.clk(clk), .arst_n(arst_n), .ctrl(i_ctrl), .bin_in(ident_sat),
		.busy(i_busy), .digit(i_digit)
	);

	// Checksum from the running sum, lifted above the control range
	assign cks_x = sum_q ^ CKS_XOR;
	assign cks   = (cks_x < CKS_FLOOR) ? cks_x + CKS_FLOOR : cks_x;

	// Select the byte of the current frame position
	always_comb begin
		unique case (state_q)
			S_START: byte_d = BYTE_START;
			S_STAT:  byte_d = status_q;
			S_WDIG:  byte_d = BYTE_DIG0 | {4'd0, w_digit};
			S_SEP:   byte_d = BYTE_SEP;
			S_IDIG:  byte_d = BYTE_DIG0 | {4'd0, i_digit};
			S_CKS:   byte_d = cks;
			default: byte_d = BYTE_ZERO;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			last_byte_q  <= 1'b0;
			frame_byte_q <= '0;
			status_q     <= '0;
			long_q       <= 1'b0;
			sum_q        <= '0;
			dig_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q  <= 1'b1;
				frame_byte_q <= byte_d;
				last_byte_q  <= (state_q == S_END);
				sum_q        <= sum_q + byte_d;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= status_byte;
						long_q   <= long_frame;
						sum_q    <= '0;
						state_q  <= S_CONV;
					end
				end
				S_CONV: begin
					if (!w_busy && !i_busy) begin
						state_q <= S_START;
					end
				end
				S_START: if (emit) state_q <= S_STAT;
				S_STAT: begin
					if (emit) begin
						dig_q   <= DIG_CW'(DIGITS - 1);
						state_q <= S_WDIG;
					end
				end
				S_WDIG: begin
					if (emit) begin
						dig_q <= dig_q - 1'b1;
						if (dig_q == '0) begin
							state_q <= long_q ? S_SEP : S_ZERO;
						end
					end
				end
				S_SEP: begin
					if (emit) begin
						dig_q   <= DIG_CW'(DIGITS - 1);
						state_q <= S_IDIG;
					end
				end
				S_IDIG: begin
					if (emit) begin
						dig_q <= dig_q - 1'b1;
						if (dig_q == '0) begin
							state_q <= S_ZERO;
						end
					end
				end
				S_ZERO: if (emit) state_q <= S_CKS;
				S_CKS:  if (emit) state_q <= S_END;
				S_END:  if (emit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_byte_q;

	// Checks on sequencing and frame content
	`WFB_ASSERT_NXT(a_busy_after_accept, accept, !in_ready, "in_ready high after accept")
	`WFB_ASSERT_IMP(a_last_is_zero, out_valid && last_byte,
		frame_byte == BYTE_ZERO, "last byte nonzero")
	`WFB_ASSERT_NXT(a_cks_floor, emit && (state_q == S_CKS),
		frame_byte >= CKS_FLOOR, "checksum below floor")
	`WFB_ASSERT_IMP(a_conv_done, (state_q == S_WDIG) || (state_q == S_IDIG),
		!w_busy && !i_busy, "digits read during conversion")
endmodule

// File: rtl/wfb_bcd_conv.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Digits are then shifted out most significant first. Depends on wfb_pkg.
`timescale 1ns / 1ps
module wfb_bcd_conv import wfb_pkg::*; #(
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcd_ctrl_t             ctrl,
	input  logic [BIN_W-1:0]      bin_in,
	output logic                  busy,
	output logic [3:0]            digit
);
	localparam int BCD_W = 4 * DIGITS;
	localparam int CNT_W = $clog2(BIN_W + 1);

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [CNT_W-1:0] cnt_q;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
				: bcd_q[4*d +: 4];
		end
	end

	// Control: bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.start) begin
			cnt_q <= CNT_W'(BIN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath: load, convert one bit per cycle, then shift out digits
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= bin_in;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (ctrl.shift) begin
			bcd_q <= bcd_q << 4;
		end
	end

	assign busy  = (cnt_q != '0);
	assign digit = bcd_q[BCD_W-1 -: 4];
endmodule
